>>> hw/rtl/csfw_pkg.sv
package csfw_pkg;

  // Semaphore count: 12-bit two's complement with saturation limits
  localparam int COUNT_W = 12;
  localparam logic signed [COUNT_W-1:0] COUNT_MAX = 12'sh7FF;
  localparam logic signed [COUNT_W-1:0] COUNT_MIN = 12'sh800;

  // Width of the initial_count register
  localparam int CFG_W = 11;

  // Operation codes
  localparam logic CMD_DOWN = 1'b0;
  localparam logic CMD_UP   = 1'b1;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;  // capture the incoming item
    logic exec;  // run the operation and register the result
  } dp_cmd_t;

endpackage

>>> hw/rtl/csfw_op_if.sv
interface csfw_op_if #(
  parameter int TASK_ID_WIDTH = 6
);
  logic                     valid;
  logic                     ready;
  logic                     cmd;
  logic [TASK_ID_WIDTH-1:0] task_id;

  modport source (output valid, output cmd, output task_id, input ready);
  modport sink (input valid, input cmd, input task_id, output ready);
endinterface

>>> hw/rtl/csfw_res_if.sv
interface csfw_res_if #(
  parameter int TASK_ID_WIDTH = 6,
  parameter int WAIT_W        = 6
);
  logic                                valid;
  logic                                ready;
  logic                                blocked;
  logic                                woken_valid;
  logic [TASK_ID_WIDTH-1:0]            woken_task;
  logic signed [csfw_pkg::COUNT_W-1:0] count_now;
  logic [WAIT_W-1:0]                   waiting_now;
  logic                                overflow;

  modport source (output valid, output blocked, output woken_valid, output woken_task,
                  output count_now, output waiting_now, output overflow, input ready);
  modport sink (input valid, input blocked, input woken_valid, input woken_task,
                input count_now, input waiting_now, input overflow, output ready);
endinterface

>>> hw/rtl/csfw_ram.sv
module csfw_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one entry, read one entry with registered data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/csfw_ctrl.sv
module csfw_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              op_valid,
  output logic              op_ready,
  output logic              res_valid,
  input  logic              res_ready,
  output csfw_pkg::dp_cmd_t dp_cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_OUT  = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  // Advance through take, execute, deliver
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (op_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = S_OUT;
      end
      S_OUT: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Drive handshakes and datapath commands
  assign op_ready    = (state == S_IDLE);
  assign res_valid   = (state == S_OUT);
  assign dp_cmd.load = (state == S_IDLE) && op_valid;
  assign dp_cmd.exec = (state == S_EXEC);

endmodule

>>> hw/rtl/csfw_dp.sv
module csfw_dp #(
  parameter int QUEUE_DEPTH   = 32,
  parameter int TASK_ID_WIDTH = 6
) (
  input  logic                                clk,
  input  logic                                rst,
  input  csfw_pkg::dp_cmd_t                   dp_cmd,
  input  logic                                cfg_wr_en,
  input  logic [csfw_pkg::CFG_W-1:0]          cfg_wr_data,
  input  logic                                op_cmd,
  input  logic [TASK_ID_WIDTH-1:0]            op_task_id,
  output logic                                blocked,
  output logic                                woken_valid,
  output logic [TASK_ID_WIDTH-1:0]            woken_task,
  output logic signed [csfw_pkg::COUNT_W-1:0] count_now,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0]    waiting_now,
  output logic                                overflow
);

  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int LEN_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [LEN_W-1:0] LEN_FULL = LEN_W'(QUEUE_DEPTH);
  localparam logic [LEN_W:0]   SUM_WRAP = (LEN_W + 1)'(QUEUE_DEPTH);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(QUEUE_DEPTH - 1);

  logic signed [csfw_pkg::COUNT_W-1:0] sem_count;
  logic signed [csfw_pkg::COUNT_W-1:0] sem_count_next;
  logic [IDX_W-1:0]                    fifo_head;
  logic [IDX_W-1:0]                    fifo_head_next;
  logic [LEN_W-1:0]                    fifo_length;
  logic [LEN_W-1:0]                    fifo_length_next;
  logic                                cmd_q;
  logic [TASK_ID_WIDTH-1:0]            task_id_q;

  logic [LEN_W:0]           wr_sum;
  logic [IDX_W-1:0]         wr_idx;
  logic                     ram_we;
  logic [TASK_ID_WIDTH-1:0] ram_rdata;
  logic                     blocked_next;
  logic                     woken_next;
  logic                     overflow_next;

  // Hold the accepted item
  always_ff @(posedge clk) begin
    if (dp_cmd.load) begin
      cmd_q     <= op_cmd;
      task_id_q <= op_task_id;
    end
  end

  // Tail slot: head plus length, wrapped once
  assign wr_sum = {{(LEN_W + 1 - IDX_W){1'b0}}, fifo_head} + {1'b0, fifo_length};
  assign wr_idx = (wr_sum >= SUM_WRAP) ? IDX_W'(wr_sum - SUM_WRAP) : IDX_W'(wr_sum);

  // Update count and queue for one operation
  always_comb begin
    sem_count_next   = sem_count;
    fifo_head_next   = fifo_head;
    fifo_length_next = fifo_length;
    blocked_next     = 1'b0;
    woken_next       = 1'b0;
    overflow_next    = 1'b0;
    ram_we           = 1'b0;
    if (cmd_q == csfw_pkg::CMD_DOWN) begin
      if (sem_count != csfw_pkg::COUNT_MIN) begin
        sem_count_next = sem_count - 12'sd1;
      end
      if (sem_count_next < 0) begin
        if (fifo_length < LEN_FULL) begin
          ram_we           = dp_cmd.exec;
          fifo_length_next = fifo_length + LEN_W'(1);
          blocked_next     = 1'b1;
        end else begin
          overflow_next = 1'b1;
        end
      end
    end else begin
      if (sem_count != csfw_pkg::COUNT_MAX) begin
        sem_count_next = sem_count + 12'sd1;
      end
      if (sem_count_next <= 0 && fifo_length != '0) begin
        woken_next       = 1'b1;
        fifo_head_next   = (fifo_head == IDX_LAST) ? '0 : fifo_head + IDX_W'(1);
        fifo_length_next = fifo_length - LEN_W'(1);
      end
    end
  end

  // Wait queue storage; read port always follows the head
  csfw_ram #(
    .WIDTH (TASK_ID_WIDTH),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_idx),
    .wdata (task_id_q),
    .raddr (fifo_head),
    .rdata (ram_rdata)
  );

  // Advance state on execute, load count on a register write
  always_ff @(posedge clk) begin
    if (rst) begin
      sem_count   <= '0;
      fifo_head   <= '0;
      fifo_length <= '0;
    end else if (cfg_wr_en) begin
      sem_count <= {1'b0, cfg_wr_data};
    end else if (dp_cmd.exec) begin
      sem_count   <= sem_count_next;
      fifo_head   <= fifo_head_next;
      fifo_length <= fifo_length_next;
    end
  end

  // Register the result
  always_ff @(posedge clk) begin
    if (dp_cmd.exec) begin
      blocked     <= blocked_next;
      woken_valid <= woken_next;
      woken_task  <= woken_next ? ram_rdata : '0;
      count_now   <= sem_count_next;
      waiting_now <= fifo_length_next;
      overflow    <= overflow_next;
    end
  end

endmodule

>>> hw/rtl/counting_semaphore_fifo_wait.sv
// Channel  Role     Handshake          Payload
// op       sink     valid / ready      cmd, task_id
// res      source   valid / ready      blocked, woken_valid, woken_task, count_now,
//                                      waiting_now, overflow
// cfg      write    cfg_wr_en          cfg_wr_data (initial_count, loads the count)
//
// One item at a time: take, execute, deliver, through the input capture register,
// the execute state and the result register.
// A stalled res holds the result and keeps op not ready.
// Reset clears count, head and length; queue entries need no clearing pass.
module counting_semaphore_fifo_wait #(
  parameter int QUEUE_DEPTH   = 32,
  parameter int TASK_ID_WIDTH = 6
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic [csfw_pkg::CFG_W-1:0]        cfg_wr_data,
  csfw_op_if.sink                           op,
  csfw_res_if.source                        res
);

  csfw_pkg::dp_cmd_t dp_cmd;

  csfw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .op_valid  (op.valid),
    .op_ready  (op.ready),
    .res_valid (res.valid),
    .res_ready (res.ready),
    .dp_cmd    (dp_cmd)
  );

  csfw_dp #(
    .QUEUE_DEPTH   (QUEUE_DEPTH),
    .TASK_ID_WIDTH (TASK_ID_WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .dp_cmd      (dp_cmd),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .op_cmd      (op.cmd),
    .op_task_id  (op.task_id),
    .blocked     (res.blocked),
    .woken_valid (res.woken_valid),
    .woken_task  (res.woken_task),
    .count_now   (res.count_now),
    .waiting_now (res.waiting_now),
    .overflow    (res.overflow)
  );

endmodule

>>> hw/rtl/csfw_chk.sv
module csfw_chk #(
  parameter int TASK_ID_WIDTH = 6,
  parameter int WAIT_W        = 6
) (
  input logic                                clk,
  input logic                                rst,
  input logic                                op_valid,
  input logic                                op_ready,
  input logic                                res_valid,
  input logic                                res_ready,
  input logic                                blocked,
  input logic                                woken_valid,
  input logic [TASK_ID_WIDTH-1:0]            woken_task,
  input logic signed [csfw_pkg::COUNT_W-1:0] count_now,
  input logic [WAIT_W-1:0]                   waiting_now,
  input logic                                overflow
);

  // A woken item never also reports blocked or overflow
  a_wake_excl: assert property (@(posedge clk) disable iff (rst)
    res_valid && woken_valid |-> !blocked && !overflow)
    else $error("woken item also reports blocked or overflow");

  // Without a wake, woken_task reads zero
  a_no_wake_id: assert property (@(posedge clk) disable iff (rst)
    res_valid && !woken_valid |-> woken_task == '0)
    else $error("woken_task nonzero without a wake");

  // A blocked caller leaves a negative count and a nonempty queue
  a_blocked_neg: assert property (@(posedge clk) disable iff (rst)
    res_valid && blocked |-> count_now < 0 && waiting_now != '0)
    else $error("blocked with nonnegative count or empty queue");

  // One item in flight: no second accept right after one
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    op_valid && op_ready |=> !op_ready)
    else $error("op ready right after an accept");

  // A stalled result holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(count_now) && $stable(waiting_now))
    else $error("stalled result changed");

endmodule

bind counting_semaphore_fifo_wait csfw_chk #(
  .TASK_ID_WIDTH (TASK_ID_WIDTH),
  .WAIT_W        ($clog2(QUEUE_DEPTH + 1))
) u_chk (
  .clk         (clk),
  .rst         (rst),
  .op_valid    (op.valid),
  .op_ready    (op.ready),
  .res_valid   (res.valid),
  .res_ready   (res.ready),
  .blocked     (res.blocked),
  .woken_valid (res.woken_valid),
  .woken_task  (res.woken_task),
  .count_now   (res.count_now),
  .waiting_now (res.waiting_now),
  .overflow    (res.overflow)
);
